// File: rtl/cnsp_pkg.sv
// ----------------------------------------------------------------------------
// cnsp_pkg: shared types and codes of the cpio newc stream parser
// Field widths, word payload structs, result kinds and error codes.
// ----------------------------------------------------------------------------
package cnsp_pkg;

   localparam int BYTE_W = 8;
   localparam int SIZE_W = 32;
   localparam int KIND_W = 2;
   localparam int ERR_W  = 4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NAME     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NAME_END = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DATA     = 2'd3;

   // Input operations
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOS  = 1'b1;

   // Sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 4'd0;
   localparam logic [ERR_W-1:0] ERR_MAGIC   = 4'd1;
   localparam logic [ERR_W-1:0] ERR_DIGIT   = 4'd2;
   localparam logic [ERR_W-1:0] ERR_NUMBER  = 4'd3;
   localparam logic [ERR_W-1:0] ERR_NAMELEN = 4'd4;
   localparam logic [ERR_W-1:0] ERR_SPACE   = 4'd5;
   localparam logic [ERR_W-1:0] ERR_UNPRINT = 4'd6;
   localparam logic [ERR_W-1:0] ERR_NONUL   = 4'd7;
   localparam logic [ERR_W-1:0] ERR_SHORT   = 4'd8;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] out_byte;
      logic [SIZE_W-1:0] member_size;
      logic              is_trailer;
      logic              last_data;
      logic [ERR_W-1:0]  error_code;
      logic              archive_done;
   } rsp_payload_type;

endpackage

// File: rtl/cnsp_if.sv
// ----------------------------------------------------------------------------
// cnsp request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cnsp_req_if;
   import cnsp_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output operation, output in_byte, input ready);
   modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface cnsp_rsp_if;
   import cnsp_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic [SIZE_W-1:0] member_size;
   logic              is_trailer;
   logic              last_data;
   logic [ERR_W-1:0]  error_code;
   logic              archive_done;

   modport source (output valid, output kind, output out_byte, output member_size,
                   output is_trailer, output last_data, output error_code,
                   output archive_done, input ready);
   modport sink   (input valid, input kind, input out_byte, input member_size,
                   input is_trailer, input last_data, input error_code,
                   input archive_done, output ready);
endinterface

// File: rtl/cnsp_parse_core.sv
// ----------------------------------------------------------------------------
// cnsp_parse_core: parser state machine and result register
// One archive word per step; state and the result word update together.
// ----------------------------------------------------------------------------
module cnsp_parse_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  cnsp_pkg::req_payload_type item,
   output cnsp_pkg::rsp_payload_type result
);
   import cnsp_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC = 3'd0,
      PH_HEX   = 3'd1,
      PH_NAME  = 3'd2,
      PH_NUL   = 3'd3,
      PH_HPAD  = 3'd4,
      PH_DATA  = 3'd5,
      PH_DPAD  = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

   function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      unique case (idx)
         3'd0:    ch = "0";
         3'd1:    ch = "7";
         3'd2:    ch = "0";
         3'd3:    ch = "7";
         3'd4:    ch = "0";
         3'd5:    ch = "1";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [BYTE_W-1:0] trailer_char(input logic [3:0] idx);
      logic [BYTE_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = "T";
         4'd1:    ch = "R";
         4'd2:    ch = "A";
         4'd3:    ch = "I";
         4'd4:    ch = "L";
         4'd5:    ch = "E";
         4'd6:    ch = "R";
         4'd7:    ch = "!";
         4'd8:    ch = "!";
         4'd9:    ch = "!";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Done after the header when trailer, else the data or the next header.
   function automatic phase_type after_header(input logic trl,
                                              input logic [SIZE_W-1:0] fsize);
      phase_type ph;
      priority if (trl)            ph = PH_DONE;
      else if (fsize == '0)        ph = PH_MAGIC;
      else                         ph = PH_DATA;
      return ph;
   endfunction

   phase_type         phase_ff, phase_in;
   logic [6:0]        count_ff, count_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic              seen_ff, seen_in;
   logic [SIZE_W-1:0] fsize_ff, fsize_in;
   logic [SIZE_W-1:0] name_rem_ff, name_rem_in;
   logic [SIZE_W-1:0] data_rem_ff, data_rem_in;
   logic [1:0]        offs_ff, offs_in;
   logic              trl_ff, trl_in;
   logic [ERR_W-1:0]  err_ff, err_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [SIZE_W-1:0] msize_ff, msize_in;
   logic              is_trl_ff, is_trl_in;
   logic              last_ff, last_in;

   logic [BYTE_W-1:0] c;
   logic              c_space;
   logic              c_hex;
   logic [3:0]        nib;
   logic              seen_now;
   logic [SIZE_W-1:0] acc_next;
   logic [3:0]        field;
   logic              name_t;

   assign c = item.in_byte;

   // Hex digit decode; a space counts as zero
   always_comb begin
      c_space = (c == " ");
      c_hex   = 1'b1;
      nib     = 4'd0;
      priority if (c >= "0" && c <= "9") begin
         nib = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         nib = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         nib = 4'(c - "A" + 8'd10);
      end else begin
         c_hex = 1'b0;
      end
   end

   assign seen_now = seen_ff | c_hex;
   assign acc_next = {acc_ff[SIZE_W-5:0], nib};
   assign field    = count_ff[6:3];
   assign name_t   = trl_ff && (count_ff == 7'd10);

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      fsize_in    = fsize_ff;
      name_rem_in = name_rem_ff;
      data_rem_in = data_rem_ff;
      offs_in     = offs_ff;
      trl_in      = trl_ff;
      err_in      = err_ff;
      kind_in     = KIND_NONE;
      byte_in     = '0;
      msize_in    = '0;
      is_trl_in   = 1'b0;
      last_in     = 1'b0;

      if (err_ff != ERR_NONE || phase_ff == PH_DONE) begin
         // ignored
      end else if (item.operation == OP_EOS) begin
         priority if (phase_ff == PH_MAGIC) err_in = ERR_MAGIC;
         else if (phase_ff == PH_HEX)       err_in = ERR_DIGIT;
         else if (phase_ff == PH_NUL)       err_in = ERR_NONUL;
         else                               err_in = ERR_SHORT;
      end else begin
         offs_in = offs_ff + 2'd1;
         unique case (phase_ff)
            PH_MAGIC: begin
               if (c != magic_char(count_ff[2:0])) begin
                  err_in = ERR_MAGIC;
               end else if (count_ff >= 7'd5) begin
                  phase_in = PH_HEX;
                  count_in = '0;
                  acc_in   = '0;
                  seen_in  = 1'b0;
               end else begin
                  count_in = count_ff + 7'd1;
               end
            end
            PH_HEX: begin
               if (c_space && seen_ff) begin
                  err_in = ERR_NUMBER;
               end else if (!c_space && !c_hex) begin
                  err_in = ERR_DIGIT;
               end else if (count_ff[2:0] != 3'd7) begin
                  acc_in   = acc_next;
                  seen_in  = seen_now;
                  count_in = count_ff + 7'd1;
               end else if (!seen_now) begin
                  err_in = ERR_NUMBER;
               end else begin
                  if (field == 4'd6)  fsize_in    = acc_next;
                  if (field == 4'd11) name_rem_in = acc_next;
                  acc_in  = '0;
                  seen_in = 1'b0;
                  if (field >= 4'd12) begin
                     // checksum field closes the header; name size was field 11
                     if (name_rem_ff < 32'd2) begin
                        err_in = ERR_NAMELEN;
                     end else begin
                        name_rem_in = name_rem_ff - 32'd1;
                        phase_in    = PH_NAME;
                        count_in    = '0;
                        trl_in      = 1'b1;
                     end
                  end else begin
                     count_in = count_ff + 7'd1;
                  end
               end
            end
            PH_NAME: begin
               priority if (c == 8'h00) begin
                  err_in = ERR_SHORT;
               end else if (c_space || (c >= 8'h09 && c <= 8'h0D)) begin
                  err_in = ERR_SPACE;
               end else if (c < 8'h20 || c > 8'h7E) begin
                  err_in = ERR_UNPRINT;
               end else begin
                  if (count_ff >= 7'd10 || c != trailer_char(count_ff[3:0])) begin
                     trl_in = 1'b0;
                  end
                  if (count_ff < 7'd11) count_in = count_ff + 7'd1;
                  kind_in     = KIND_NAME;
                  byte_in     = c;
                  name_rem_in = name_rem_ff - 32'd1;
                  if (name_rem_ff == 32'd1) phase_in = PH_NUL;
               end
            end
            PH_NUL: begin
               if (c != 8'h00) begin
                  err_in = ERR_NONUL;
               end else begin
                  kind_in   = KIND_NAME_END;
                  msize_in  = fsize_ff;
                  is_trl_in = name_t;
                  trl_in    = name_t;
                  if (offs_in == 2'd0) begin
                     phase_in    = after_header(name_t, fsize_ff);
                     count_in    = '0;
                     data_rem_in = fsize_ff;
                  end else begin
                     phase_in = PH_HPAD;
                  end
               end
            end
            PH_HPAD: begin
               if (offs_in == 2'd0) begin
                  phase_in    = after_header(trl_ff, fsize_ff);
                  count_in    = '0;
                  data_rem_in = fsize_ff;
               end
            end
            PH_DATA: begin
               kind_in     = KIND_DATA;
               byte_in     = c;
               data_rem_in = data_rem_ff - 32'd1;
               if (data_rem_ff == 32'd1) begin
                  last_in = 1'b1;
                  if (offs_in == 2'd0) begin
                     phase_in = PH_MAGIC;
                     count_in = '0;
                  end else begin
                     phase_in = PH_DPAD;
                  end
               end
            end
            PH_DPAD: begin
               if (offs_in == 2'd0) begin
                  phase_in = PH_MAGIC;
                  count_in = '0;
               end
            end
            PH_DONE: begin
               // unreachable here
            end
            default: begin
            end
         endcase
      end

      // an error blanks the result word
      if (err_in != ERR_NONE) begin
         kind_in   = KIND_NONE;
         byte_in   = '0;
         msize_in  = '0;
         is_trl_in = 1'b0;
         last_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         count_ff    <= '0;
         acc_ff      <= '0;
         seen_ff     <= 1'b0;
         fsize_ff    <= '0;
         name_rem_ff <= '0;
         data_rem_ff <= '0;
         offs_ff     <= '0;
         trl_ff      <= 1'b1;
         err_ff      <= ERR_NONE;
         kind_ff     <= KIND_NONE;
         byte_ff     <= '0;
         msize_ff    <= '0;
         is_trl_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         fsize_ff    <= fsize_in;
         name_rem_ff <= name_rem_in;
         data_rem_ff <= data_rem_in;
         offs_ff     <= offs_in;
         trl_ff      <= trl_in;
         err_ff      <= err_in;
         kind_ff     <= kind_in;
         byte_ff     <= byte_in;
         msize_ff    <= msize_in;
         is_trl_ff   <= is_trl_in;
         last_ff     <= last_in;
      end
   end

   // error and done state change only on a step, so they serve the result word
   assign result.kind         = kind_ff;
   assign result.out_byte     = byte_ff;
   assign result.member_size  = msize_ff;
   assign result.is_trailer   = is_trl_ff;
   assign result.last_data    = last_ff;
   assign result.error_code   = err_ff;
   assign result.archive_done = (err_ff == ERR_NONE) && (phase_ff == PH_DONE);

`ifndef NO_ASSERTIONS
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |=> $stable(err_ff))
      else $error("sticky error changed");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |=> (phase_ff == PH_DONE))
      else $error("left done phase");

   a_name_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME) |-> (name_rem_ff != '0))
      else $error("name phase with no characters left");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> (kind_ff == KIND_DATA && err_ff == ERR_NONE))
      else $error("last flag on a non-data word");

   a_error_blanks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |-> (kind_ff == KIND_NONE && msize_ff == '0))
      else $error("result word not blanked after error");
`endif

endmodule

// File: rtl/cpio_newc_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser_unit: cpio newc archive stream parser
// Checks a 070701 archive byte by byte, emits name and data bytes.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   req_if    in   valid / ready    operation, in_byte
//   rsp_if    out  valid / ready    kind, out_byte, member_size, is_trailer,
//                                   last_data, error_code, archive_done
//
// Flow: every accepted word yields exactly one response word; one word per
//   cycle unless the response is held; input register, result register.
// The parser step is a single state update between those two registers.
// Reset: synchronous, active high; both stages empty, parser at the magic.
// Stalls: a held response keeps the result register; the input register
//   takes one more word, then req_if.ready drops until the result is taken.
//
module cpio_newc_stream_parser_unit (
   input  logic       clock,
   input  logic       reset,
   cnsp_req_if.sink   req_if,
   cnsp_rsp_if.source rsp_if
);
   import cnsp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff, in_item_in;
   logic            out_valid_ff, out_valid_in;
   logic            advance;
   logic            req_take;
   rsp_payload_type result;

   // input word moves into the parser when the result register is free
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      in_item_in   = in_item_ff;
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_take) begin
         in_item_in.operation = req_if.operation;
         in_item_in.in_byte   = req_if.in_byte;
         in_valid_in          = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   cnsp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.kind         = result.kind;
   assign rsp_if.out_byte     = result.out_byte;
   assign rsp_if.member_size  = result.member_size;
   assign rsp_if.is_trailer   = result.is_trailer;
   assign rsp_if.last_data    = result.last_data;
   assign rsp_if.error_code   = result.error_code;
   assign rsp_if.archive_done = result.archive_done;

endmodule
